[rtl/core/saa_pkg.sv]
// Shared types and constants for the subnet address allocator.
package saa_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int ADDR_W      = 32;

    localparam logic [ADDR_W-1:0] MASK_RESET = 32'hFFFF_FF00;
    localparam logic [7:0]        BYTE_ALL   = 8'hFF;
    localparam logic [7:0]        BYTE_ZERO  = 8'h00;
    localparam logic [7:0]        BYTE_ONE   = 8'h01;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [0:0] {
        REG_START = 1'b0,
        REG_MASK  = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_REUSED    = 3'd0,
        ST_FRESH     = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_FREED     = 3'd3,
        ST_REJECTED  = 3'd4
    } status_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic              clear;
        logic [ADDR_W-1:0] data;
    } stack_ctl_t;

endpackage

[rtl/core/saa_stack.sv]
// LIFO free stack: top entry in a register, the rest in a memory with a registered read.
module saa_stack
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  saa_pkg::stack_ctl_t         ctl,
    output logic [saa_pkg::ADDR_W-1:0]  top,
    output logic [saa_pkg::CNT_W-1:0]   count
);

    logic [saa_pkg::ADDR_W-1:0] mem [saa_pkg::STACK_DEPTH];

    logic [saa_pkg::CNT_W-1:0]  count_reg;
    logic [saa_pkg::CNT_W-1:0]  count_next;
    logic [saa_pkg::ADDR_W-1:0] tos_reg;
    logic [saa_pkg::ADDR_W-1:0] tos_next;
    logic [saa_pkg::ADDR_W-1:0] below_reg;

    logic                       wr_en;
    logic [saa_pkg::CNT_W-1:0]  wr_pos;
    logic [saa_pkg::IDX_W-1:0]  wr_addr;
    logic [saa_pkg::CNT_W-1:0]  rd_pos;
    logic [saa_pkg::IDX_W-1:0]  rd_addr;

    always_comb
    begin
        count_next = count_reg;
        tos_next   = tos_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.push)
        begin
            count_next = count_reg + saa_pkg::CNT_W'(1);
            tos_next   = ctl.data;
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - saa_pkg::CNT_W'(1);
            tos_next   = below_reg;
        end
    end

    // A push spills the old top into the memory slot just below the new top.
    assign wr_en   = ctl.push && !ctl.clear && (count_reg != '0);
    assign wr_pos  = count_reg - saa_pkg::CNT_W'(1);
    assign wr_addr = wr_pos[saa_pkg::IDX_W-1:0];
    // Keep the entry below the next top ready for a pop in the next cycle.
    assign rd_pos  = count_next - saa_pkg::CNT_W'(2);
    assign rd_addr = rd_pos[saa_pkg::IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= tos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            below_reg <= tos_reg;
        end
        else
        begin
            below_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
    end

    assign top   = tos_reg;
    assign count = count_reg;

endmodule

[rtl/core/subnet_address_allocator_unit.sv]
// Subnet address allocator: allocate/free requests served from a free stack or a cursor.
//
// Input channel (in_valid/in_stall, command, address): command 0 allocates an
// address, command 1 returns one. Output channel (out_valid/out_stall,
// granted_address, status) carries exactly one result per request, in order.
// A request is captured in an input register and processed from there into the
// output register, which drives out_valid. One request per cycle is sustained
// while out_stall is low; the free stack keeps its top in a register and
// prefetches the entry below it from its memory, so pops and pushes can follow
// each other in consecutive cycles.
// When out_stall holds a result, the pending request waits in the input register
// and in_stall rises only once that register is occupied.
// Configuration writes (cfg_write, cfg_index, cfg_data) are for the user to make
// while idle; the block does not enforce it. Index 0 loads the start address,
// reloads the cursor and empties the stack; index 1 loads the subnet mask. Reset
// sets start 0 (exhausted), mask 0xFFFFFF00, an empty stack and empty channel
// registers; no clearing pass.
module subnet_address_allocator_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [31:0] address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] granted_address,
    output logic [2:0]  status,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic                       in_valid_reg;
    logic                       cmd_reg;
    logic [saa_pkg::ADDR_W-1:0] addr_reg;

    logic                       out_valid_reg;
    logic [saa_pkg::ADDR_W-1:0] granted_reg;
    logic [2:0]                 status_reg;
    logic [saa_pkg::ADDR_W-1:0] granted_next;
    saa_pkg::status_t           status_next;

    logic [saa_pkg::ADDR_W-1:0] start_reg;
    logic [saa_pkg::ADDR_W-1:0] mask_reg;
    logic [saa_pkg::ADDR_W-1:0] cursor_reg;
    logic [saa_pkg::ADDR_W-1:0] cursor_next;

    logic                       fire;
    logic                       load;
    logic [saa_pkg::ADDR_W-1:0] subnet;
    logic [saa_pkg::ADDR_W-1:0] step;
    logic [saa_pkg::ADDR_W-1:0] cand;
    logic [1:0]                 skip;
    logic                       free_ok;

    saa_pkg::stack_ctl_t        sctl;
    logic [saa_pkg::ADDR_W-1:0] stack_top;
    logic [saa_pkg::CNT_W-1:0]  stack_count;
    logic                       stack_empty;
    logic                       stack_full;

    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign load     = in_valid && !in_stall;

    assign subnet      = start_reg & mask_reg;
    assign stack_empty = (stack_count == '0);
    assign stack_full  = (stack_count >= saa_pkg::CNT_W'(saa_pkg::STACK_DEPTH));
    assign free_ok     = ((addr_reg & mask_reg) == subnet) && !stack_full;

    // The cursor never hands out low bytes 255, 0 and 1: it jumps straight to byte 2.
    assign step = cursor_reg + 32'd1;
    always_comb
    begin
        case (step[7:0])
            saa_pkg::BYTE_ALL:  skip = 2'd3;
            saa_pkg::BYTE_ZERO: skip = 2'd2;
            saa_pkg::BYTE_ONE:  skip = 2'd1;
            default:            skip = 2'd0;
        endcase
    end
    assign cand = step + {30'd0, skip};

    always_comb
    begin
        granted_next = '0;
        status_next  = saa_pkg::ST_EXHAUSTED;
        cursor_next  = cursor_reg;
        sctl.push    = 1'b0;
        sctl.pop     = 1'b0;
        sctl.clear   = cfg_write && (cfg_index == saa_pkg::REG_START);
        sctl.data    = addr_reg;
        if (cmd_reg == saa_pkg::CMD_ALLOC)
        begin
            if (!stack_empty)
            begin
                sctl.pop     = fire;
                granted_next = stack_top;
                status_next  = saa_pkg::ST_REUSED;
            end
            else if (cursor_reg != '0)
            begin
                if ((cand & mask_reg) != subnet)
                begin
                    cursor_next = '0;
                    status_next = saa_pkg::ST_EXHAUSTED;
                end
                else
                begin
                    cursor_next  = cand;
                    granted_next = cand;
                    status_next  = saa_pkg::ST_FRESH;
                end
            end
        end
        else
        begin
            if (free_ok)
            begin
                sctl.push   = fire;
                status_next = saa_pkg::ST_FREED;
            end
            else
            begin
                status_next = saa_pkg::ST_REJECTED;
            end
        end
    end

    saa_stack u_stack
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sctl),
        .top   (stack_top),
        .count (stack_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            mask_reg   <= saa_pkg::MASK_RESET;
            cursor_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == saa_pkg::REG_START)
            begin
                start_reg  <= cfg_data;
                cursor_reg <= cfg_data;
            end
            else
            begin
                mask_reg <= cfg_data;
            end
        end
        else if (fire)
        begin
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg  <= command;
            addr_reg <= address;
        end
        if (fire)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign granted_address = granted_reg;
    assign status          = status_reg;

endmodule

[bench/allocation_checker.sv]
// Checker for the subnet address allocator: tracks requests, predicts grants, compares results.
`timescale 1ns / 1ps

module allocation_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        command,
    input  logic [31:0] address,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] granted_address,
    input  logic [2:0]  status,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);

    typedef struct {
        logic [31:0]      addr;
        saa_pkg::status_t code;
    } grant_t;

    // Shadow of the allocator state
    logic [31:0] start_q;
    logic [31:0] mask_q;
    logic [31:0] cursor_q;
    logic [31:0] free_list [saa_pkg::STACK_DEPTH];
    int          depth_q;

    grant_t expected_grants[$];

    function automatic grant_t predict_grant(input saa_pkg::cmd_t cmd,
                                             input logic [31:0] addr);
        grant_t      g;
        logic [31:0] subnet;
        logic [31:0] nxt;
        subnet = start_q & mask_q;
        g.addr = '0;
        if (cmd == saa_pkg::CMD_ALLOC)
        begin
            if (depth_q != 0)
            begin
                depth_q--;
                g.addr = free_list[depth_q];
                g.code = saa_pkg::ST_REUSED;
            end
            else if (cursor_q != '0)
            begin
                // skip broadcast, network and gateway low bytes in turn
                nxt = cursor_q + 32'd1;
                if (nxt[7:0] == saa_pkg::BYTE_ALL)
                    nxt = nxt + 32'd1;
                if (nxt[7:0] == saa_pkg::BYTE_ZERO)
                    nxt = nxt + 32'd1;
                if (nxt[7:0] == saa_pkg::BYTE_ONE)
                    nxt = nxt + 32'd1;
                if ((nxt & mask_q) != subnet)
                begin
                    cursor_q = '0;
                    g.code   = saa_pkg::ST_EXHAUSTED;
                end
                else
                begin
                    cursor_q = nxt;
                    g.addr   = nxt;
                    g.code   = saa_pkg::ST_FRESH;
                end
            end
            else
            begin
                g.code = saa_pkg::ST_EXHAUSTED;
            end
        end
        else
        begin
            if ((addr & mask_q) != subnet || depth_q >= saa_pkg::STACK_DEPTH)
            begin
                g.code = saa_pkg::ST_REJECTED;
            end
            else
            begin
                free_list[depth_q] = addr;
                depth_q++;
                g.code = saa_pkg::ST_FREED;
            end
        end
        return g;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (mismatches < 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, act_v);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        grant_t exp_item;
        grant_t new_item;
        if (!rst_n)
        begin
            start_q     = '0;
            mask_q      = saa_pkg::MASK_RESET;
            cursor_q    = '0;
            depth_q     = 0;
            mismatches  = 0;
            outstanding = 0;
            expected_grants.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                if (saa_pkg::reg_idx_t'(cfg_index) == saa_pkg::REG_START)
                begin
                    start_q  = cfg_data;
                    cursor_q = cfg_data;
                    depth_q  = 0;
                end
                else
                begin
                    mask_q = cfg_data;
                end
            end
            if (in_valid && !in_stall)
            begin
                new_item        = predict_grant(saa_pkg::cmd_t'(command), address);
                expected_grants = {expected_grants, new_item};
            end
            if (out_valid && !out_stall)
            begin
                if (expected_grants.size() == 0)
                begin
                    note_mismatch("unexpected transfer, status", '0, {29'd0, status});
                end
                else
                begin
                    exp_item = expected_grants.pop_front();
                    if (granted_address !== exp_item.addr)
                        note_mismatch("granted_address", exp_item.addr, granted_address);
                    if (status !== exp_item.code)
                        note_mismatch("status", {29'd0, exp_item.code}, {29'd0, status});
                end
            end
            outstanding = expected_grants.size();
        end
    end

endmodule

[bench/subnet_address_allocator_unit_test.sv]
// Testbench top for the subnet address allocator: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module subnet_address_allocator_unit_test;

    localparam int TOTAL_REQUESTS = 1850;
    localparam int CALM_TAIL      = 150;
    localparam int LONG_HOLD      = 64;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int FILL_COUNT     = 260;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        command;
    logic [31:0] address;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] granted_address;
    logic [2:0]  status;
    logic        cfg_write;
    logic        cfg_index;
    logic [31:0] cfg_data;

    int          mismatches;
    int          outstanding;
    int          requests_sent = 0;
    int          cycle_count   = 0;
    bit          calm          = 1'b0;
    logic        hold_req;
    logic [31:0] start_reg     = '0;
    logic [31:0] mask_reg      = saa_pkg::MASK_RESET;

    always #10 clk = ~clk;

    subnet_address_allocator_unit dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .address         (address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .granted_address (granted_address),
        .status          (status),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    allocation_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .address         (address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .granted_address (granted_address),
        .status          (status),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // address inside the current subnet with random host bits
    function automatic logic [31:0] host_addr();
        return (start_reg & mask_reg) | ($urandom & ~mask_reg);
    endfunction

    task automatic send_request(input saa_pkg::cmd_t cmd, input logic [31:0] addr);
        calm = (requests_sent >= TOTAL_REQUESTS - CALM_TAIL);
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        address  <= addr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    // let every outstanding grant come back, then a little slack for the pipeline
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input saa_pkg::reg_idx_t idx, input logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == saa_pkg::REG_START)
            start_reg = value;
        else
            mask_reg = value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : receiver
        bit held;
        held = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        int          len;
        int          alloc_pct;
        int          mask_sel;
        logic [31:0] st;
        logic [31:0] mk;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        command   <= saa_pkg::CMD_ALLOC;
        address   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= saa_pkg::REG_START;
        cfg_data  <= '0;
        hold_req  <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state: cursor zero, so fresh allocation is exhausted at once
        send_request(saa_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
        send_request(saa_pkg::CMD_FREE,  32'h0000_0042);
        send_request(saa_pkg::CMD_ALLOC, 32'h0000_0000);
        send_request(saa_pkg::CMD_FREE,  32'h0000_0100);
        send_request(saa_pkg::CMD_ALLOC, 32'h0000_0000);
        drain();

        // cursor runs over the 255/0/1 low bytes and out of the subnet
        write_reg(saa_pkg::REG_START, 32'hC0A8_01FC);
        repeat (4) send_request(saa_pkg::CMD_ALLOC, 32'h0000_0000);
        send_request(saa_pkg::CMD_FREE,  32'hC0A8_01FF);
        send_request(saa_pkg::CMD_ALLOC, 32'h0000_0000);
        drain();

        // wider subnet: step from low byte 254 across 255, 0 and 1
        write_reg(saa_pkg::REG_MASK, 32'hFFFF_0000);
        write_reg(saa_pkg::REG_START, 32'hC0A8_00FD);
        repeat (4) send_request(saa_pkg::CMD_ALLOC, 32'h0000_0000);
        drain();

        // empty mask, cursor wraps past all ones
        write_reg(saa_pkg::REG_MASK, 32'h0);
        write_reg(saa_pkg::REG_START, 32'hFFFF_FFFC);
        repeat (6) send_request(saa_pkg::CMD_ALLOC, 32'h0000_0000);
        drain();

        // fill the stack past full, the receiver holding off once at the start, then empty it
        write_reg(saa_pkg::REG_MASK, saa_pkg::MASK_RESET);
        write_reg(saa_pkg::REG_START, 32'h0A00_0010);
        hold_req <= 1'b1;
        repeat (FILL_COUNT) send_request(saa_pkg::CMD_FREE, host_addr());
        repeat (FILL_COUNT + 4) send_request(saa_pkg::CMD_ALLOC, 32'h0000_0000);

        // random phases, each with its own mask and often a new start
        while (requests_sent < TOTAL_REQUESTS)
        begin
            if (requests_sent < TOTAL_REQUESTS - CALM_TAIL)
            begin
                drain();
                mask_sel = $urandom_range(0, 4);
                case (mask_sel)
                    0:       mk = 32'hFFFF_FF00;
                    1:       mk = 32'hFFFF_FE00;
                    2:       mk = 32'hFFFF_FFF0;
                    3:       mk = 32'hFFFF_0000;
                    default: mk = 32'h0000_0000;
                endcase
                write_reg(saa_pkg::REG_MASK, mk);
                if ($urandom_range(0, 3) != 0)
                begin
                    st = $urandom;
                    // start near the top of the subnet so exhaustion comes soon
                    if ($urandom_range(0, 1) == 0)
                        st = st | (~mk & ~32'h1F);
                    if ($urandom_range(0, 9) == 0)
                        st = '0;
                    write_reg(saa_pkg::REG_START, st);
                end
                len = $urandom_range(20, 80);
                if (len > TOTAL_REQUESTS - requests_sent)
                    len = TOTAL_REQUESTS - requests_sent;
            end
            else
            begin
                len = TOTAL_REQUESTS - requests_sent;
            end
            alloc_pct = $urandom_range(20, 80);
            repeat (len)
            begin
                if ($urandom_range(1, 100) <= alloc_pct)
                    send_request(saa_pkg::CMD_ALLOC, $urandom);
                else if ($urandom_range(0, 4) == 0)
                    send_request(saa_pkg::CMD_FREE, $urandom);
                else
                    send_request(saa_pkg::CMD_FREE, host_addr());
            end
        end

        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
